// ===== hdl/rv64im_integer_alu_top_defines.svh =====
// Assertion macros for the rv64im integer ALU.
// Used by the top level; no other dependencies.
`ifndef RV64IM_INTEGER_ALU_TOP_DEFINES_SVH
`define RV64IM_INTEGER_ALU_TOP_DEFINES_SVH
`ifndef SYNTH
`define RVALU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RVALU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RVALU_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define RVALU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/rvalu_pkg.sv =====
// Shared types, operation codes and helpers for the rv64im integer ALU.
// No dependencies.
package rvalu_pkg;

    localparam int XLEN  = 64;
    localparam int NCELL = 64;

    typedef enum logic [4:0] {
        OP_ADD    = 5'd0,  OP_ADDW  = 5'd1,  OP_SUB   = 5'd2,  OP_SUBW   = 5'd3,
        OP_MUL    = 5'd4,  OP_MULH  = 5'd5,  OP_MULHSU = 5'd6, OP_MULHU  = 5'd7,
        OP_MULW   = 5'd8,  OP_DIV   = 5'd9,  OP_DIVW  = 5'd10, OP_DIVU   = 5'd11,
        OP_DIVUW  = 5'd12, OP_REM   = 5'd13, OP_REMW  = 5'd14, OP_REMU   = 5'd15,
        OP_REMUW  = 5'd16, OP_AND   = 5'd17, OP_OR    = 5'd18, OP_XOR    = 5'd19,
        OP_SLL    = 5'd20, OP_SLLW  = 5'd21, OP_SRL   = 5'd22, OP_SRLW   = 5'd23,
        OP_SRA    = 5'd24, OP_SRAW  = 5'd25, OP_SLT   = 5'd26, OP_SLTU   = 5'd27
    } op_t;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } kind_t;

    typedef struct packed {
        logic            valid;
        logic [4:0]      op;
        kind_t           kind;
        logic            ovf;
        logic            neg_q;
        logic            neg_r;
        logic [XLEN-1:0] res;   // finished result for simple ops and special cases
        logic [XLEN-1:0] corr;  // signed correction of the high product
    } meta_t;

    typedef struct packed {
        meta_t           meta;
        logic [XLEN-1:0] x;     // high product / partial remainder
        logic [XLEN-1:0] y;     // low product + multiplier / dividend + quotient
        logic [XLEN-1:0] z;     // multiplicand / divisor
    } cell_t;

    typedef struct packed {
        logic            valid;
        logic [4:0]      op;
        logic [XLEN-1:0] result;
        logic            ovf;
    } out_t;

    function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

// ===== hdl/rvalu_prep.sv =====
// Decode and operand preparation: simple ops, special cases, chain setup.
// Depends on rvalu_pkg.
module rvalu_prep import rvalu_pkg::*; (
    input  logic            valid,
    input  logic [4:0]      mode,
    input  logic [XLEN-1:0] a,
    input  logic [XLEN-1:0] b,
    output cell_t           c
);

    localparam logic [XLEN-1:0] ALL64  = {XLEN{1'b1}};
    localparam logic [XLEN-1:0] SIGN64 = {1'b1, {(XLEN-1){1'b0}}};
    localparam logic [XLEN-1:0] MIN32  = {{33{1'b1}}, 31'd0};

    logic [XLEN-1:0] a32, b32, sum, dif, sumw, difw;
    logic [XLEN-1:0] abs_a, abs_b, abs_a32, abs_b32, corr_s;
    logic [5:0]      sh6;
    logic [4:0]      sh5;
    logic            bz64, bz32, dov64, dov32;
    logic            ov_add, ov_addw, ov_sub, ov_subw;

    assign a32     = sx32(a);
    assign b32     = sx32(b);
    assign sh6     = b[5:0];
    assign sh5     = b[4:0];
    assign sum     = a + b;
    assign dif     = a - b;
    assign sumw    = sx32(sum);
    assign difw    = sx32(dif);
    assign abs_a   = a[63] ? (~a + 64'd1) : a;
    assign abs_b   = b[63] ? (~b + 64'd1) : b;
    assign abs_a32 = a32[63] ? (~a32 + 64'd1) : a32;
    assign abs_b32 = b32[63] ? (~b32 + 64'd1) : b32;
    assign corr_s  = (a[63] ? b : 64'd0) + (b[63] ? a : 64'd0);
    assign bz64    = (b == 64'd0);
    assign bz32    = (b[31:0] == 32'd0);
    assign dov64   = (a == SIGN64) && (b == ALL64);
    assign dov32   = (a32 == MIN32) && (b32 == ALL64);
    assign ov_add  = ((a ^ sum) & (b ^ sum)) >> 63 != 64'd0;
    assign ov_addw = ((a32 ^ sumw) & (b32 ^ sumw)) >> 63 != 64'd0;
    assign ov_sub  = ((a ^ b) & (a ^ dif)) >> 63 != 64'd0;
    assign ov_subw = ((a32 ^ b32) & (a32 ^ difw)) >> 63 != 64'd0;

    always_comb begin
        c            = '0;
        c.meta.valid = valid;
        c.meta.op    = mode;
        c.meta.kind  = K_SIMPLE;
        unique case (mode)
            OP_ADD:  begin c.meta.res = sum;  c.meta.ovf = ov_add;  end
            OP_ADDW: begin c.meta.res = sumw; c.meta.ovf = ov_addw; end
            OP_SUB:  begin c.meta.res = dif;  c.meta.ovf = ov_sub;  end
            OP_SUBW: begin c.meta.res = difw; c.meta.ovf = ov_subw; end
            OP_MUL, OP_MULH: begin
                c.meta.kind = K_MUL; c.y = b; c.z = a; c.meta.corr = corr_s;
            end
            OP_MULHSU: begin
                c.meta.kind = K_MUL; c.y = b; c.z = a;
                c.meta.corr = a[63] ? b : 64'd0;
            end
            OP_MULHU: begin c.meta.kind = K_MUL; c.y = b; c.z = a; end
            OP_MULW:  begin c.meta.kind = K_MUL; c.y = b32; c.z = a32; end
            OP_DIV: begin
                if (bz64) begin
                    c.meta.res = ALL64;
                end else if (dov64) begin
                    c.meta.res = a; c.meta.ovf = 1'b1;
                end else begin
                    c.meta.kind = K_DIV; c.y = abs_a; c.z = abs_b;
                    c.meta.neg_q = a[63] ^ b[63];
                end
            end
            OP_DIVW: begin
                if (bz32) begin
                    c.meta.res = ALL64;
                end else if (dov32) begin
                    c.meta.res = a32; c.meta.ovf = 1'b1;
                end else begin
                    c.meta.kind = K_DIV; c.y = abs_a32; c.z = abs_b32;
                    c.meta.neg_q = a32[63] ^ b32[63];
                end
            end
            OP_DIVU: begin
                if (bz64) c.meta.res = ALL64;
                else begin c.meta.kind = K_DIV; c.y = a; c.z = b; end
            end
            OP_DIVUW: begin
                if (bz32) c.meta.res = ALL64;
                else begin
                    c.meta.kind = K_DIV;
                    c.y = {32'd0, a[31:0]}; c.z = {32'd0, b[31:0]};
                end
            end
            OP_REM: begin
                if (bz64) c.meta.res = a;
                else if (dov64) c.meta.res = 64'd0;
                else begin
                    c.meta.kind = K_DIV; c.y = abs_a; c.z = abs_b;
                    c.meta.neg_r = a[63];
                end
            end
            OP_REMW: begin
                if (bz32) c.meta.res = a32;
                else if (dov32) c.meta.res = 64'd0;
                else begin
                    c.meta.kind = K_DIV; c.y = abs_a32; c.z = abs_b32;
                    c.meta.neg_r = a32[63];
                end
            end
            OP_REMU: begin
                if (bz64) c.meta.res = a;
                else begin c.meta.kind = K_DIV; c.y = a; c.z = b; end
            end
            OP_REMUW: begin
                if (bz32) c.meta.res = a32;
                else begin
                    c.meta.kind = K_DIV;
                    c.y = {32'd0, a[31:0]}; c.z = {32'd0, b[31:0]};
                end
            end
            OP_AND:  c.meta.res = a & b;
            OP_OR:   c.meta.res = a | b;
            OP_XOR:  c.meta.res = a ^ b;
            OP_SLL:  c.meta.res = a << sh6;
            OP_SLLW: c.meta.res = sx32(a << sh5);
            OP_SRL:  c.meta.res = a >> sh6;
            OP_SRLW: c.meta.res = sx32({32'd0, a[31:0]} >> sh5);
            OP_SRA:  c.meta.res = $unsigned($signed(a) >>> sh6);
            OP_SRAW: c.meta.res = $unsigned($signed(a32) >>> sh5);
            OP_SLT:  c.meta.res = {63'd0, $signed(a) < $signed(b)};
            OP_SLTU: c.meta.res = {63'd0, a < b};
            default: c.meta.res = 64'd0;
        endcase
    end

endmodule

// ===== hdl/rvalu_cell.sv =====
// One step of the shared multiply/divide chain: a shift-add or a restoring step.
// Depends on rvalu_pkg.
module rvalu_cell import rvalu_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cell_t d,
    output cell_t q
);

    cell_t       q_reg, q_next;
    logic [64:0] t, msum;
    logic [65:0] diff;
    logic        ge;

    assign t    = {d.x, d.y[63]};
    assign diff = {1'b0, t} - {2'b00, d.z};
    assign ge   = ~diff[65];
    assign msum = {1'b0, d.x} + (d.y[0] ? {1'b0, d.z} : 65'd0);

    always_comb begin
        q_next = d;
        unique case (d.meta.kind)
            K_MUL: begin
                q_next.x = msum[64:1];
                q_next.y = {msum[0], d.y[63:1]};
            end
            K_DIV: begin
                q_next.x = ge ? diff[63:0] : t[63:0];
                q_next.y = {d.y[62:0], ge};
            end
            default: q_next = d;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.meta.valid <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== hdl/rvalu_post.sv =====
// Result finishing: sign fix of quotient/remainder, high product correction, output register.
// Depends on rvalu_pkg.
module rvalu_post import rvalu_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cell_t d,
    output out_t  q
);

    out_t            q_reg, q_next;
    logic [XLEN-1:0] hi, quo, rem, v;
    logic            is_rem, is_w;

    assign hi     = d.x - d.meta.corr;
    assign quo    = d.meta.neg_q ? (~d.y + 64'd1) : d.y;
    assign rem    = d.meta.neg_r ? (~d.x + 64'd1) : d.x;
    assign is_rem = (d.meta.op == OP_REM) || (d.meta.op == OP_REMW) ||
                    (d.meta.op == OP_REMU) || (d.meta.op == OP_REMUW);
    assign is_w   = (d.meta.op == OP_DIVW) || (d.meta.op == OP_DIVUW) ||
                    (d.meta.op == OP_REMW) || (d.meta.op == OP_REMUW);
    assign v      = is_rem ? rem : quo;

    always_comb begin
        q_next.valid  = d.meta.valid;
        q_next.op     = d.meta.op;
        q_next.result = d.meta.res;
        q_next.ovf    = d.meta.ovf;
        unique case (d.meta.kind)
            K_MUL: begin
                if (d.meta.op == OP_MUL) begin
                    q_next.result = d.y;
                    q_next.ovf    = hi != {64{d.y[63]}};
                end else if (d.meta.op == OP_MULW) begin
                    q_next.result = sx32(d.y);
                    q_next.ovf    = d.y != sx32(d.y);
                end else begin
                    q_next.result = hi;
                    q_next.ovf    = 1'b0;
                end
            end
            K_DIV: begin
                q_next.result = is_w ? sx32(v) : v;
                q_next.ovf    = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== hdl/rv64im_integer_alu_top.sv =====
// Top level of the rv64im integer ALU: decode, 64-cell mul/div chain, result stage.
// Depends on rvalu_pkg, rvalu_prep, rvalu_cell, rvalu_post and the defines header.
//
// Fully pipelined RV64IM integer execute unit. Every transaction enters a chain of
// 64 identical cells (each retires one multiplier bit or one quotient bit) and then
// a finishing register, whatever the operation. One transaction is accepted per
// cycle while the result side takes results; the whole chain stalls together when
// m_tready is low (s_tready = !m_tvalid || m_tready). Divide by zero yields all
// ones, remainder by zero the dividend, signed divide overflow the dividend with
// the overflow flag set; DIVUW/REMUW results are sign-extended. No state survives
// between transactions.
`include "rv64im_integer_alu_top_defines.svh"
module rv64im_integer_alu_top import rvalu_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] operand_a, [127:64] operand_b
    input  logic [4:0]   s_tuser,   // [4:0] mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // [63:0] result_value, [64] overflow_flag, [71:65] zero
);

    logic  en;
    cell_t chain [0:NCELL];
    out_t  res;

    // global advance: the output register is free or being emptied this cycle
    assign en       = !res.valid || m_tready;
    assign s_tready = en;

    rvalu_prep u_prep (
        .valid (s_tvalid),
        .mode  (s_tuser),
        .a     (s_tdata[63:0]),
        .b     (s_tdata[127:64]),
        .c     (chain[0])
    );

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        rvalu_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d       (chain[i]),
            .q       (chain[i+1])
        );
    end

    rvalu_post u_post (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (chain[NCELL]),
        .q       (res)
    );

    assign m_tvalid = res.valid;
    assign m_tdata  = {7'd0, res.ovf, res.result};

    // an accepted transaction lands in the first cell
    `RVALU_ASSERT_NEXT(a_enter, aclk, aresetn, s_tvalid && s_tready, chain[1].meta.valid)
    // the last cell hands its transaction to the output register
    `RVALU_ASSERT_NEXT(a_leave, aclk, aresetn, chain[NCELL].meta.valid && en, m_tvalid)
    // overflow only from signed add/sub/mul/div forms
    `RVALU_ASSERT_NOW(a_ovf_op, aclk, aresetn, m_tvalid && res.ovf,
        res.op == OP_ADD || res.op == OP_ADDW || res.op == OP_SUB || res.op == OP_SUBW ||
        res.op == OP_MUL || res.op == OP_MULW || res.op == OP_DIV || res.op == OP_DIVW)

endmodule

// ===== tb/rv64im_integer_alu_top_tb.sv =====
// Self-checking testbench for the rv64im integer ALU top level.
// Depends on rvalu_pkg and rv64im_integer_alu_top; a class holds expected results.
module rv64im_integer_alu_top_tb import rvalu_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PIPE_LATENCY   = 65;

    typedef struct packed {
        logic [63:0] value;
        logic        ovf;
    } alu_res_t;

    // Expected-result store plus predictor.
    class alu_scoreboard;
        alu_res_t pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        static function logic [63:0] sx(input logic [63:0] v);
            return {{32{v[31]}}, v[31:0]};
        endfunction

        static function alu_res_t predict(input logic [4:0] mode, input logic [63:0] a,
                                          input logic [63:0] b);
            alu_res_t         o;
            logic [63:0]      a32, b32, t;
            logic signed [127:0] ps;
            logic [127:0]     pu;
            logic signed [63:0] sa, sb;
            o   = '0;
            a32 = sx(a);
            b32 = sx(b);
            sa  = a;
            sb  = b;
            case (mode)
                OP_ADD: begin
                    o.value = a + b;
                    o.ovf   = (a[63] == b[63]) && (o.value[63] != a[63]);
                end
                OP_ADDW: begin
                    t = a32 + b32;
                    o.value = sx(t);
                    o.ovf   = t != o.value;
                end
                OP_SUB: begin
                    o.value = a - b;
                    o.ovf   = (a[63] != b[63]) && (o.value[63] != a[63]);
                end
                OP_SUBW: begin
                    t = a32 - b32;
                    o.value = sx(t);
                    o.ovf   = t != o.value;
                end
                OP_MUL: begin
                    ps = sa * sb;
                    o.value = ps[63:0];
                    o.ovf   = ps[127:64] != {64{ps[63]}};
                end
                OP_MULH: begin
                    ps = sa * sb;
                    o.value = ps[127:64];
                end
                OP_MULHSU: begin
                    ps = $signed({{64{a[63]}}, a}) * $signed({64'd0, b});
                    o.value = ps[127:64];
                end
                OP_MULHU: begin
                    pu = {64'd0, a} * {64'd0, b};
                    o.value = pu[127:64];
                end
                OP_MULW: begin
                    t = $signed(a32) * $signed(b32);
                    o.value = sx(t);
                    o.ovf   = t != o.value;
                end
                OP_DIV, OP_REM: begin
                    if (b == 0)
                        o.value = (mode == OP_DIV) ? '1 : a;
                    else if (a == 64'h8000_0000_0000_0000 && b == '1) begin
                        o.value = (mode == OP_DIV) ? a : '0;
                        o.ovf   = mode == OP_DIV;
                    end else
                        o.value = (mode == OP_DIV) ? sa / sb : sa % sb;
                end
                OP_DIVW, OP_REMW: begin
                    if (b[31:0] == 0)
                        o.value = (mode == OP_DIVW) ? '1 : a32;
                    else if (a[31:0] == 32'h8000_0000 && b[31:0] == '1) begin
                        o.value = (mode == OP_DIVW) ? a32 : '0;
                        o.ovf   = mode == OP_DIVW;
                    end else
                        o.value = (mode == OP_DIVW) ? $signed(a32) / $signed(b32)
                                                    : $signed(a32) % $signed(b32);
                end
                OP_DIVU:  o.value = (b == 0) ? '1 : a / b;
                OP_REMU:  o.value = (b == 0) ? a : a % b;
                OP_DIVUW: o.value = (b[31:0] == 0) ? '1 : sx({32'd0, a[31:0] / b[31:0]});
                OP_REMUW: o.value = (b[31:0] == 0) ? a32 : sx({32'd0, a[31:0] % b[31:0]});
                OP_AND:   o.value = a & b;
                OP_OR:    o.value = a | b;
                OP_XOR:   o.value = a ^ b;
                OP_SLL:   o.value = a << b[5:0];
                OP_SLLW:  o.value = sx(a << b[4:0]);
                OP_SRL:   o.value = a >> b[5:0];
                OP_SRLW:  o.value = sx({32'd0, a[31:0]} >> b[4:0]);
                OP_SRA:   o.value = sa >>> b[5:0];
                OP_SRAW:  o.value = $signed(a32) >>> b[4:0];
                OP_SLT:   o.value = {63'd0, sa < sb};
                OP_SLTU:  o.value = {63'd0, a < b};
                default:  o = '0;
            endcase
            return o;
        endfunction

        function void note_operation(input logic [4:0] mode, input logic [63:0] a,
                                     input logic [63:0] b);
            pending.push_back(predict(mode, a, b));
        endfunction

        function void check_result(input logic [71:0] data);
            alu_res_t want;
            if (pending.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[63:0] !== want.value) begin
                $error("result_value: expected %h, actual %h", want.value, data[63:0]);
                errors++;
            end
            if (data[64] !== want.ovf) begin
                $error("overflow_flag: expected %b, actual %b", want.ovf, data[64]);
                errors++;
            end
            if (data[71:65] !== '0) begin
                $error("m_tdata pad: expected 0, actual %h", data[71:65]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [4:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    alu_scoreboard sb = new();
    int  send_idle_pct = 0;   // chance of a gap before each transaction
    int  recv_stall_pct = 0;  // chance of dropping m_tready per cycle
    int  idle_cycles = 0;

    rv64im_integer_alu_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: sample at rising edge, change ready at falling edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one transaction and hold it until accepted.
    task automatic send_op(input logic [4:0] mode, input logic [63:0] a, input logic [63:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {b, a};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_operation(mode, a, b);
        @(negedge aclk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000;
            3: v = 64'h7FFF_FFFF_FFFF_FFFF;
            4: v = {{32{v[31]}}, v[31:0]};
            5: v = 64'($urandom_range(16));
            default: ;
        endcase
        return v;
    endfunction

    initial begin : stimulus
        logic [63:0] edges [6];
        logic [4:0]  m;
        logic [63:0] a, b;
        edges = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0000,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_8000_0000};
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every code on corner operands, divide special cases.
        for (int op = 0; op < 32; op++)
            send_op(op[4:0], edges[op % 6], edges[(op + 2) % 6]);
        send_op(OP_DIV,  64'h8000_0000_0000_0000, '1);
        send_op(OP_REM,  64'h8000_0000_0000_0000, '1);
        send_op(OP_DIVW, 64'h1234_5678_8000_0000, 64'h0000_0001_FFFF_FFFF);
        send_op(OP_REMW, 64'h0000_0000_8000_0000, '1);
        send_op(OP_DIVU, 64'h55, 64'd0);
        send_op(OP_REMUW, 64'hABCD_0000_F000_0001, 64'hFFFF_FFFF_0000_0000);
        send_op(OP_DIVUW, 64'hFFFF_FFFF, 64'h1_0000_0000);
        send_op(OP_SLL, '1, 64'hFFFF_FFFF_FFFF_FFC1);
        send_op(OP_SRAW, 64'h8000_0000, 64'h3F);
        end_burst();
        drain();   // pause the sender until everything has come back

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 80 : 23) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 80 : 23) : 0;
            for (int i = 0; i < 375; i++) begin
                m = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 28))
                                              : 5'($urandom_range(27));
                a = pick_operand();
                b = pick_operand();
                send_op(m, a, b);
            end
            end_burst();
        end
        drain();
        repeat (PIPE_LATENCY + 10) @(negedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
